// ===== sv/idct_8x8_level_shift_assert.svh =====
// Assertion macros shared by the inverse DCT block.
`ifndef IDCT_8X8_LEVEL_SHIFT_ASSERT_SVH
`define IDCT_8X8_LEVEL_SHIFT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define IDCT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define IDCT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define IDCT_ASSERT_IMP(name, ante, cons, msg)
`define IDCT_ASSERT_NXT(name, ante, cons, msg)

`endif

`endif

// ===== sv/idct_pkg.sv =====
// Types, constants and the cosine basis table for the 8x8 inverse DCT.
package idct_pkg;

    localparam int BLOCK_DIM  = 8;
    localparam int COEFF_BITS = 12;
    localparam int IDX_W      = $clog2(BLOCK_DIM);
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int DEPTH      = BLOCK_DIM * BLOCK_DIM;
    localparam int BASIS_W    = 16;
    localparam int SAMPLE_W   = 16;
    // Each term fits in COEFF_BITS + 28 bits, 64 terms add six more, plus sign.
    localparam int ACC_W      = COEFF_BITS + 34;
    localparam int RND_SHIFT  = 30;
    localparam int QW         = ACC_W + 1 - RND_SHIFT;
    localparam int LEVEL      = 128;

    typedef struct packed {
        logic [IDX_W-1:0]             coeff_row;
        logic [IDX_W-1:0]             coeff_col;
        logic signed [COEFF_BITS-1:0] coeff_value;
        logic                         last_coeff;
    } coeff_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]           sample_row;
        logic [IDX_W-1:0]           sample_col;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       last_sample;
    } sample_item_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              acc_clr;
        logic              round_en;
        logic              out_load;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              last;
    } idct_cmd_t;

    typedef struct packed {
        logic mac_busy;
        logic out_full;
    } idct_sts_t;

    // cos(m pi / 16) in Q1.14 for m in 0..8.
    function automatic logic signed [BASIS_W-1:0] cos_q14(input logic [3:0] m);
        logic signed [BASIS_W-1:0] val;
        case (m)
            4'd0:    val = 16'sd16384;
            4'd1:    val = 16'sd16069;
            4'd2:    val = 16'sd15137;
            4'd3:    val = 16'sd13623;
            4'd4:    val = 16'sd11585;
            4'd5:    val = 16'sd9102;
            4'd6:    val = 16'sd6270;
            4'd7:    val = 16'sd3196;
            default: val = 16'sd0;
        endcase
        return val;
    endfunction

    // C(u) cos((2p+1) u pi / 16) in Q1.14.
    function automatic logic signed [BASIS_W-1:0] basis(input logic [IDX_W-1:0] p,
                                                        input logic [IDX_W-1:0] u);
        logic [6:0] prod;
        logic [4:0] m;
        logic signed [BASIS_W-1:0] val;
        prod = {3'b000, p, 1'b1} * {4'b0000, u};
        m    = prod[4:0];
        if (m > 5'd16)
        begin
            m = 5'(6'd32 - {1'b0, m});
        end
        if (u == '0)
        begin
            val = 16'sd11585;
        end
        else if (m > 5'd8)
        begin
            val = -cos_q14(4'(5'd16 - m));
        end
        else
        begin
            val = cos_q14(m[3:0]);
        end
        return val;
    endfunction

endpackage

// ===== sv/idct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module idct_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/idct_dp.sv =====
// Datapath: coefficient store, two-stage multiplier, accumulator, rounding and result register.
module idct_dp import idct_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  idct_cmd_t    cmd,
    input  coeff_item_t  in_item,
    input  logic         out_ready,
    output logic         out_valid,
    output sample_item_t out_item,
    output idct_sts_t    sts
);

    logic [COEFF_BITS-1:0] rd_data;

    logic                  v0_reg, v1_reg, v2_reg;
    logic [ADDR_W-1:0]     a0_reg;
    logic [IDX_W-1:0]      vidx_reg;

    logic signed [COEFF_BITS+BASIS_W-1:0]   p1_reg, p1_next;
    logic signed [COEFF_BITS+2*BASIS_W-1:0] p2_reg, p2_next;
    logic signed [ACC_W-1:0]                acc_reg, acc_next;
    logic [ACC_W-1:0]                       mag_reg;
    logic                                   neg_reg;

    logic                   out_valid_reg, out_valid_next;
    sample_item_t           out_reg, out_next;

    logic [ACC_W:0]          rsum;
    logic [QW-1:0]           qmag;
    logic signed [QW+1:0]    qsig;
    logic signed [QW+1:0]    qlev;
    logic signed [SAMPLE_W-1:0] sat;

    idct_ram #(
        .WIDTH (COEFF_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr ({in_item.coeff_row, in_item.coeff_col}),
        .wr_data (in_item.coeff_value),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_data)
    );

    // First product uses the row frequency u, second the column frequency v.
    assign p1_next = $signed(rd_data) * basis(cmd.row, a0_reg[ADDR_W-1:IDX_W]);
    assign p2_next = p1_reg * basis(cmd.col, vidx_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_clr)
        begin
            acc_next = '0;
        end
        else if (v2_reg)
        begin
            acc_next = acc_reg + ACC_W'(p2_reg);
        end
    end

    // Round the magnitude half away from zero, restore the sign, shift level, saturate.
    always_comb
    begin
        rsum = {1'b0, mag_reg} + (ACC_W+1)'(64'd1 << (RND_SHIFT - 1));
        qmag = rsum[ACC_W:RND_SHIFT];
        qsig = neg_reg ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
        qlev = qsig + (QW+2)'(LEVEL);
        if (qlev > (QW+2)'(32767))
        begin
            sat = 16'sh7FFF;
        end
        else if (qlev < -(QW+2)'(32768))
        begin
            sat = -16'sh8000;
        end
        else
        begin
            sat = qlev[SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_next.sample_row   = cmd.row;
            out_next.sample_col   = cmd.col;
            out_next.sample_value = sat;
            out_next.last_sample  = cmd.last;
            out_valid_next        = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v0_reg        <= cmd.rd_en;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a0_reg   <= cmd.rd_addr;
        vidx_reg <= a0_reg[IDX_W-1:0];
        if (v0_reg)
        begin
            p1_reg <= p1_next;
        end
        if (v1_reg)
        begin
            p2_reg <= p2_next;
        end
        acc_reg <= acc_next;
        if (cmd.round_en)
        begin
            neg_reg <= acc_reg[ACC_W-1];
            mag_reg <= acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        end
        out_reg <= out_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_item     = out_reg;
    assign sts.mac_busy = v0_reg | v1_reg | v2_reg;
    assign sts.out_full = out_valid_reg;

endmodule

// ===== sv/idct_ctrl.sv =====
// Controller: takes coefficient items, then sequences 64 sums of 64 products each.
module idct_ctrl import idct_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_last,
    input  logic      out_ready,
    input  idct_sts_t sts,
    output logic      in_ready,
    output idct_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_ROUND,
        S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic              last_pos;

    assign last_pos = (row_reg == IDX_W'(BLOCK_DIM - 1)) && (col_reg == IDX_W'(BLOCK_DIM - 1));

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.rd_addr  = k_reg;
        cmd.row      = row_reg;
        cmd.col      = col_reg;
        cmd.last     = last_pos;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.wr_en = 1'b1;
                    if (in_last)
                    begin
                        cmd.acc_clr = 1'b1;
                        k_next      = '0;
                        row_next    = '0;
                        col_next    = '0;
                        state_next  = S_MAC;
                    end
                end
            end
            S_MAC:
            begin
                cmd.rd_en = 1'b1;
                k_next    = k_reg + 1'b1;
                if (k_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!sts.mac_busy)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.round_en = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                // The result register may still hold the previous sample.
                if (!sts.out_full || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    if (last_pos)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.acc_clr = 1'b1;
                        k_next      = '0;
                        col_next    = col_reg + 1'b1;
                        if (col_reg == IDX_W'(BLOCK_DIM - 1))
                        begin
                            row_next = row_reg + 1'b1;
                        end
                        state_next = S_MAC;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

endmodule

// ===== sv/idct_8x8_level_shift.sv =====
// Top level of the 8x8 inverse DCT with level shift.
//
//   channel | handshake          | item
//   --------+--------------------+------------------------------------------
//   in      | in_valid/in_ready  | coeff_item_t: one coefficient and its u,v
//   out     | out_valid/out_ready| sample_item_t: one sample and its row,col
//
// A coefficient item is taken whenever one is offered while the block waits for input.
// After the item marked last, each of the 64 samples is built in order: all 64
// coefficients are read from the store through the one shared multiply-accumulate
// unit, its pipeline drains, the magnitude is taken, and it is rounded into the result
// register. A stalled output holds the next sample back. Reset clears control only;
// the coefficient store keeps no valid bits.
`include "idct_8x8_level_shift_assert.svh"

module idct_8x8_level_shift import idct_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  coeff_item_t  in_item,
    output logic         out_valid,
    input  logic         out_ready,
    output sample_item_t out_item
);

    idct_cmd_t cmd;
    idct_sts_t sts;

    idct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_item.last_coeff),
        .out_ready (out_ready),
        .sts       (sts),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    idct_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (in_item),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item),
        .sts       (sts)
    );

    `IDCT_ASSERT_IMP(a_idle_pipe_empty, in_ready, !sts.mac_busy, "item taken while MAC busy")
    `IDCT_ASSERT_IMP(a_no_overwrite, cmd.out_load, !sts.out_full || out_ready, "result overwritten")
    `IDCT_ASSERT_IMP(a_no_rd_wr, cmd.rd_en, !cmd.wr_en, "store read and written together")
    `IDCT_ASSERT_NXT(a_last_to_idle, cmd.out_load && cmd.last, in_ready, "no return to idle")

endmodule
